/* design/gmps_pkg.sv */
// gmps_pkg: widths, types and helpers shared by the grid maximum path sum block
// no dependencies; used by gmps_seq, gmps_dp and grid_max_path_sum
package gmps_pkg;

    localparam int MAX_N = 128;
    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int VAL_W = 8;
    localparam int CFG_W = 8;
    localparam int SUM_W = 15;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CFG_W-1:0] cfg_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam sum_t SUM_MAX = {SUM_W{1'b1}};

    // cell tag carried from the traversal counters into the compute stage
    typedef struct packed {
        idx_t col;
        logic row_first;
        logic col_first;
        logic has_right;
        logic last_row;
        logic last_cell;
        logic fwd;
        val_t value;
    } cell_tag_t;

    function automatic cnt_t eff_size(input cfg_t g);
        int unsigned v;
        v = 32'(g);
        if (v == 0) v = 1;
        if (v > MAX_N) v = MAX_N;
        return cnt_t'(v);
    endfunction

endpackage

/* design/gmps_ram.sv */
// gmps_ram: generic single-write, single-read memory with registered read data
// no dependencies
module gmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/gmps_seq.sv */
// gmps_seq: grid size register, row and column counters, input stage and row memory read
// depends on gmps_pkg
module gmps_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  gmps_pkg::cfg_t          cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  gmps_pkg::val_t          s_cell_value,
    input  logic                    hold,
    output logic                    cell_valid,
    output gmps_pkg::cell_tag_t     cell_tag,
    output logic                    rd_en,
    output gmps_pkg::idx_t          rd_addr
);

    gmps_pkg::cfg_t      grid_size_reg;
    gmps_pkg::idx_t      row_index_reg, row_index_next;
    gmps_pkg::idx_t      col_index_reg, col_index_next;
    logic                cell_valid_reg, cell_valid_next;
    gmps_pkg::cell_tag_t cell_tag_reg;
    gmps_pkg::cell_tag_t tag_in;
    gmps_pkg::cnt_t      n_eff;
    gmps_pkg::cnt_t      col_cnt, row_cnt;
    logic                adv, accept, has_right, last_row;

    assign n_eff   = gmps_pkg::eff_size(grid_size_reg);
    assign col_cnt = gmps_pkg::cnt_t'(col_index_reg);
    assign row_cnt = gmps_pkg::cnt_t'(row_index_reg);

    assign adv     = cell_valid_reg && !hold;
    assign s_ready = !cell_valid_reg || adv;
    assign accept  = s_valid && s_ready;

    assign has_right = gmps_pkg::cnt_t'(col_cnt + gmps_pkg::cnt_t'(1)) < n_eff;
    assign last_row  = gmps_pkg::cnt_t'(row_cnt + gmps_pkg::cnt_t'(1)) >= n_eff;

    assign rd_addr = gmps_pkg::idx_t'(col_index_reg + gmps_pkg::idx_t'(1));
    assign rd_en   = accept && has_right;

    always_comb begin
        tag_in.col       = col_index_reg;
        tag_in.row_first = (row_index_reg == '0);
        tag_in.col_first = (col_index_reg == '0);
        tag_in.has_right = has_right;
        tag_in.last_row  = last_row;
        tag_in.last_cell = !has_right && last_row;
        // entry written by the cell now leaving the compute stage
        tag_in.fwd       = adv && has_right && (cell_tag_reg.col == rd_addr);
        tag_in.value     = s_cell_value;
    end

    always_comb begin
        row_index_next  = row_index_reg;
        col_index_next  = col_index_reg;
        cell_valid_next = cell_valid_reg;
        if (accept) begin
            cell_valid_next = 1'b1;
            if (has_right) begin
                col_index_next = rd_addr;
            end else if (!last_row) begin
                col_index_next = '0;
                row_index_next = gmps_pkg::idx_t'(row_index_reg + gmps_pkg::idx_t'(1));
            end else begin
                col_index_next = '0;
                row_index_next = '0;
            end
        end else if (adv) begin
            cell_valid_next = 1'b0;
        end
        if (cfg_we) begin
            row_index_next = '0;
            col_index_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= gmps_pkg::cfg_t'(1);
            row_index_reg  <= '0;
            col_index_reg  <= '0;
            cell_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                grid_size_reg <= cfg_wdata;
            end
            row_index_reg  <= row_index_next;
            col_index_reg  <= col_index_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_tag_reg <= tag_in;
        end
    end

    assign cell_valid = cell_valid_reg;
    assign cell_tag   = cell_tag_reg;

`ifndef SYNTHESIS
    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        col_cnt < n_eff)
        else $error("column counter outside grid");

    a_row_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt < n_eff)
        else $error("row counter outside grid");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> cell_valid_reg)
        else $error("accepted cell missing from compute stage");

    a_hold_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid_reg && !adv) |=> (cell_valid_reg && $stable(cell_tag_reg)))
        else $error("held cell changed");
`endif

endmodule

/* design/gmps_dp.sv */
// gmps_dp: compute stage with three-way max, saturating add, final-row maximum and result register
// depends on gmps_pkg
module gmps_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cell_valid,
    input  gmps_pkg::cell_tag_t     cell_tag,
    input  gmps_pkg::sum_t          rd_data,
    output logic                    hold,
    output logic                    wr_en,
    output gmps_pkg::idx_t          wr_addr,
    output gmps_pkg::sum_t          wr_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gmps_pkg::sum_t          m_best_sum
);

    gmps_pkg::sum_t above_reg, left_reg, first_reg, fwd_data_reg;
    gmps_pkg::sum_t last_best_reg, last_best_next;
    gmps_pkg::sum_t m_best_sum_reg;
    logic           m_valid_reg, m_valid_next;
    gmps_pkg::sum_t right, above, best, sum, run_best;
    logic [gmps_pkg::SUM_W:0] sum_wide;
    logic           adv;

    assign right = cell_tag.fwd ? fwd_data_reg : rd_data;
    assign above = cell_tag.col_first ? first_reg : above_reg;

    always_comb begin
        best = '0;
        if (!cell_tag.row_first) begin
            best = above;
            if (!cell_tag.col_first && (left_reg > best)) begin
                best = left_reg;
            end
            if (cell_tag.has_right && (right > best)) begin
                best = right;
            end
        end
    end

    assign sum_wide = {1'b0, best} + (gmps_pkg::SUM_W + 1)'(cell_tag.value);
    assign sum      = (sum_wide > {1'b0, gmps_pkg::SUM_MAX}) ? gmps_pkg::SUM_MAX
                                                             : sum_wide[gmps_pkg::SUM_W-1:0];
    assign run_best = (cell_tag.last_row && (sum > last_best_reg)) ? sum : last_best_reg;

    assign hold = cell_valid && cell_tag.last_cell && m_valid_reg && !m_ready;
    assign adv  = cell_valid && !hold;

    assign wr_en   = adv;
    assign wr_addr = cell_tag.col;
    assign wr_data = sum;

    always_comb begin
        last_best_next = last_best_reg;
        m_valid_next   = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (adv) begin
            if (cell_tag.last_cell) begin
                last_best_next = '0;
                m_valid_next   = 1'b1;
            end else begin
                last_best_next = run_best;
            end
        end
        if (cfg_we) begin
            last_best_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_best_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_best_reg <= last_best_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_reg     <= above;
            above_reg    <= right;
            fwd_data_reg <= sum;
            if (cell_tag.col_first) begin
                first_reg <= sum;
            end
            if (cell_tag.last_cell) begin
                m_best_sum_reg <= run_best;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_best_sum = m_best_sum_reg;

endmodule

/* design/grid_max_path_sum.sv */
// grid_max_path_sum: top level, row memory plus traversal and compute stages
// depends on gmps_pkg, gmps_ram, gmps_seq, gmps_dp
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_cell_value[7:0]
// m_        out        m_valid / m_ready    m_best_sum[14:0]
// cfg_      in         cfg_we               cfg_wdata[7:0]
//
// one cell per cycle, set by the single read port of the row memory
// result is registered once the last cell of a grid leaves the compute stage
// input stalls only while the last cell of a grid waits on an untaken result
// reset clears control state only, no memory clearing pass
module grid_max_path_sum (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [7:0]              cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_cell_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [14:0]             m_best_sum
);

    logic                cell_valid, hold;
    gmps_pkg::cell_tag_t cell_tag;
    logic                rd_en, wr_en;
    gmps_pkg::idx_t      rd_addr, wr_addr;
    gmps_pkg::sum_t      rd_data, wr_data;

    gmps_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .hold         (hold),
        .cell_valid   (cell_valid),
        .cell_tag     (cell_tag),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr)
    );

    gmps_ram #(
        .WIDTH (gmps_pkg::SUM_W),
        .DEPTH (gmps_pkg::MAX_N)
    ) u_row_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gmps_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cell_valid (cell_valid),
        .cell_tag   (cell_tag),
        .rd_data    (rd_data),
        .hold       (hold),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_best_sum (m_best_sum)
    );

endmodule

/* verif/grid_max_path_sum_check.sv */
// grid_max_path_sum_check: watches the size, cell and result ports of the block,
// predicts each grid's best top-to-bottom path sum and compares it per transaction
// depends on gmps_pkg
module grid_max_path_sum_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_cell_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [14:0] m_best_sum,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    gmps_pkg::sum_t row_best [gmps_pkg::MAX_N];
    gmps_pkg::sum_t left_prev;
    gmps_pkg::sum_t final_row_max;
    int unsigned    row_no;
    int unsigned    col_no;
    gmps_pkg::cfg_t size_reg;
    gmps_pkg::sum_t owed_sums [$];
    gmps_pkg::sum_t next_sum;
    int             owed_count = 0;
    int             fail_count = 0;

    assign pending = owed_count;
    assign errors  = fail_count;

    function automatic int unsigned side_len();
        if (size_reg == '0) return 1;
        if (size_reg > gmps_pkg::MAX_N) return gmps_pkg::MAX_N;
        return 32'(size_reg);
    endfunction

    function automatic void restart_grid();
        left_prev     = '0;
        final_row_max = '0;
        row_no        = 0;
        col_no        = 0;
    endfunction

    function automatic void fold_cell(input gmps_pkg::val_t v);
        int unsigned              n;
        int unsigned              c;
        gmps_pkg::sum_t           above;
        gmps_pkg::sum_t           best;
        logic [gmps_pkg::SUM_W:0] total;
        n = side_len();
        c = col_no;
        above = row_best[c];
        best = '0;
        if (row_no > 0) begin
            best = above;
            if (c > 0 && left_prev > best) best = left_prev;
            if (c + 1 < n && row_best[c + 1] > best) best = row_best[c + 1];
        end
        total = {1'b0, best} + {{(gmps_pkg::SUM_W + 1 - gmps_pkg::VAL_W){1'b0}}, v};
        if (total > {1'b0, gmps_pkg::SUM_MAX}) total = {1'b0, gmps_pkg::SUM_MAX};
        left_prev = above;
        row_best[c] = total[gmps_pkg::SUM_W-1:0];
        if (row_no + 1 >= n && total[gmps_pkg::SUM_W-1:0] > final_row_max)
            final_row_max = total[gmps_pkg::SUM_W-1:0];
        if (c + 1 < n) begin
            col_no = c + 1;
        end else if (row_no + 1 < n) begin
            col_no    = 0;
            row_no    = row_no + 1;
            left_prev = '0;
        end else begin
            owed_sums.insert(owed_sums.size(), final_row_max);
            restart_grid();
        end
    endfunction

    function automatic void log_miss(input string what, input gmps_pkg::sum_t want,
                                     input gmps_pkg::sum_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_reg = 8'd1;
            foreach (row_best[i]) row_best[i] = '0;
            restart_grid();
            owed_sums.delete();
            owed_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_sums.size() == 0) begin
                    log_miss("result transaction with no grid outstanding", '0, m_best_sum);
                end else begin
                    next_sum = owed_sums.pop_front();
                    if (m_best_sum !== next_sum)
                        log_miss("best_sum mismatch", next_sum, m_best_sum);
                end
            end
            if (cfg_we) begin
                size_reg = cfg_wdata;
                restart_grid();
            end
            if (s_valid && s_ready) fold_cell(s_cell_value);
            owed_count <= owed_sums.size();
        end
    end

endmodule

/* verif/grid_max_path_sum_test.sv */
// grid_max_path_sum_test: clock, reset and stimulus for grid_max_path_sum, with
// directed grids, an oversized setting, a long result stall and random grids
// depends on gmps_pkg, grid_max_path_sum and grid_max_path_sum_check
module grid_max_path_sum_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE       = 4;
    localparam int LONG_HOLD    = 40;
    localparam int RANDOM_ITEMS = 420;
    localparam int MIN_GRIDS    = 12;
    localparam int MIN_PHASES   = 4;
    localparam int PHASE_ITEMS  = 75;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic           aclk;
    logic           aresetn      = 1'b0;
    logic           cfg_we       = 1'b0;
    gmps_pkg::cfg_t cfg_wdata    = '0;
    logic           s_valid      = 1'b0;
    gmps_pkg::val_t s_cell_value = '0;
    logic           m_ready      = 1'b0;
    logic           s_ready;
    logic           m_valid;
    logic [14:0]    m_best_sum;
    int             pending;
    int             errors;

    int          send_pct = 0;
    int          recv_pct = 0;
    int          hold_req = 0;
    int unsigned side     = 1;

    grid_max_path_sum uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_sum   (m_best_sum)
    );

    grid_max_path_sum_check path_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_sum   (m_best_sum),
        .pending      (pending),
        .errors       (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("grid_max_path_sum_test: errors");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int held;
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                m_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge aclk);
                hold_seen = hold_seen + 1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_pct);
            end
        end
    end

    task automatic set_mode(input idle_mode_t m);
        case (m)
            IDLE_NONE: begin send_pct = 0;  recv_pct <= 0;  end
            IDLE_SEND: begin send_pct = 78; recv_pct <= 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct <= 78; end
            default:   begin send_pct = 8;  recv_pct <= 8;  end
        endcase
    endtask

    task automatic send_cell(input gmps_pkg::val_t v);
        while ($urandom_range(0, 99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic gmps_pkg::val_t pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return gmps_pkg::val_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic gmps_pkg::cfg_t pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3) return gmps_pkg::cfg_t'($urandom_range(7, 14));
        return gmps_pkg::cfg_t'($urandom_range(1, 6));
    endfunction

    task automatic feed_cells(input int unsigned count, input bit all_max);
        int unsigned i;
        for (i = 0; i < count; i++) send_cell(all_max ? gmps_pkg::val_t'('1) : pick_value());
    endtask

    // wait for every owed result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_grid(input gmps_pkg::cfg_t g);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        side = (g == '0) ? 1 : ((g > gmps_pkg::MAX_N) ? gmps_pkg::MAX_N : 32'(g));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned fed;
        int unsigned start;
        int unsigned grids;
        int unsigned cells;
        int unsigned phase;
        int unsigned pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // size still at its reset value
        set_mode(IDLE_NONE);
        send_cell('0);
        send_cell('1);
        drain();
        set_grid('0);
        send_cell(8'h80);
        drain();
        set_grid(8'd2);
        feed_cells(4, 1'b1);
        drain();
        set_grid(8'd3);
        feed_cells(9, 1'b0);
        // abandon a grid part way, then start over
        feed_cells(4, 1'b0);
        drain();
        set_grid(8'd2);
        feed_cells(4, 1'b0);
        drain();

        // oversized setting, first full row of top values and the start of the next
        set_mode(IDLE_BOTH);
        set_grid('1);
        feed_cells(side + 2, 1'b1);
        drain();

        // results held back while cells keep coming
        set_mode(IDLE_NONE);
        set_grid(8'd1);
        hold_req <= hold_req + 1;
        feed_cells(16, 1'b0);
        drain();

        fed   = 0;
        grids = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS || grids < MIN_GRIDS || phase < MIN_PHASES) begin
            set_mode(idle_mode_t'(phase % 4));
            set_grid(pick_size());
            start = fed;
            while (fed - start < PHASE_ITEMS) begin
                cells = side * side;
                pick  = $urandom_range(0, 99);
                if (pick < 12 && cells > 1) begin
                    cells = $urandom_range(1, cells - 1);
                    feed_cells(cells, 1'b0);
                    fed += cells;
                    drain();
                    set_grid(pick_size());
                end else begin
                    feed_cells(cells, 1'b0);
                    fed += cells;
                    grids++;
                    if (pick >= 90) begin
                        drain();
                    end else if (pick >= 80) begin
                        drain();
                        set_grid(pick_size());
                    end
                end
            end
            drain();
            phase++;
        end

        if (errors == 0) begin
            $display("grid_max_path_sum_test: clean");
        end else begin
            $display("grid_max_path_sum_test: errors");
        end
        $finish;
    end

endmodule
